/* hw/rtl/spectral_reassignment_bin_assert.svh */
// ============================================================================
// Assertion macros for the spectral reassignment bin
// Shared property forms with a synchronous active-low reset as disable.
// ============================================================================
`ifndef SPECTRAL_REASSIGNMENT_BIN_ASSERT_SVH
`define SPECTRAL_REASSIGNMENT_BIN_ASSERT_SVH

// Implication in the same cycle.
`define SRB_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define SRB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/srb_pkg.sv */
// ============================================================================
// srb_pkg
// Types and constants of the spectral reassignment bin pipeline.
// ============================================================================
`default_nettype none

package srb_pkg;

    typedef enum logic [1:0] {
        CFG_FFT_SIZE_LOG2   = 2'd0,
        CFG_SAMPLE_RATE_HZ  = 2'd1,
        CFG_ENERGY_FLOOR_DB = 2'd2
    } t_cfg_idx;

    localparam logic [3:0]         FFT_LOG2_RST = 4'd11;
    localparam logic [17:0]        FS_RST       = 18'd48000;
    localparam logic signed [15:0] FLOOR_RST    = -16'sd20480;

    localparam logic [17:0]        LOG_DB_Q16   = 18'd197284;
    localparam logic [21:0]        INV_2PI_Q24  = 22'd2670177;
    localparam logic signed [15:0] DB_MIN       = -16'sd30720;
    localparam logic signed [15:0] DB_MAX       = 16'sd12288;
    localparam logic [20:0]        FREQ_MAX     = 21'h1FFFFF;
    localparam logic [24:0]        FREQ_MIN_Q4  = 25'd16;

    // Quotient bits of the frequency ratio: Q32 with two integer bits.
    localparam int FSTEPS = 34;
    localparam int SQ_STEPS = 16;

    // Stage numbers of the pipeline.
    localparam int STG_IN       = 1;
    localparam int STG_SUM      = 2;
    localparam int STG_PREP     = 3;
    localparam int STG_EXP      = 4;
    localparam int STG_NORM     = 5;
    localparam int STG_LNET     = STG_NORM + SQ_STEPS + 1;
    localparam int STG_PROD     = STG_LNET + 1;
    localparam int STG_DB       = STG_PROD + 1;
    localparam int STG_QUAL     = STG_DB + 1;
    localparam int STG_DIV_END  = STG_PREP + FSTEPS;
    localparam int STG_CMUL     = STG_DIV_END + 1;
    localparam int STG_C        = STG_CMUL + 1;
    localparam int STG_CFS      = STG_C + 1;
    localparam int STG_CORR     = STG_CFS + 1;
    localparam int STG_OUT      = STG_CORR + 1;

    // Per-bin values that ride alongside the arithmetic.
    typedef struct packed {
        logic [20:0]        centre;
        logic               tneg;
        logic               fneg;
        logic               k_ok;
        logic               p_nz;
        logic signed [15:0] db;
        logic               qual;
        logic signed [23:0] toff;
        logic               rok;
    } t_side;

    // State of the two long dividers that share the divisor p.
    typedef struct packed {
        logic [63:0] p;
        logic [63:0] tfeed;
        logic [63:0] ffeed;
        logic [63:0] trem;
        logic [63:0] frem;
        logic [23:0] tq;
        logic [33:0] fq;
        logic        tovf;
        logic        fovf;
    } t_div;

endpackage

`default_nettype wire

/* hw/rtl/spectral_reassignment_bin.sv */
// ============================================================================
// spectral_reassignment_bin
// Per-bin level, centre frequency and Auger-Flandrin reassignment of
// frequency and time, as one fully pipelined datapath.
//
//   Channel   Handshake                      Payload
//   -------   ----------------------------   ---------------------------------
//   request   start / busy                   x, ramp and deriv spectra, bin
//   result    o_result_valid (strobe)        level, frequency, offset, flag
//   config    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One request is taken every cycle; busy is always low. Each result appears
// at the output stage STG_OUT, in order, for a single cycle.
// The pipeline depth is set by the 34-step long divider of the frequency ratio,
// one quotient bit per stage; the log2 squarings run alongside it.
// Reset is synchronous and active low; it clears the valid pipeline and
// loads the register defaults. The receiver cannot stall the results.
// ============================================================================
`default_nettype none
`include "spectral_reassignment_bin_assert.svh"

module spectral_reassignment_bin #(
    parameter int MAX_FFT_LOG2 = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_x_real,
    input  logic signed [31:0] i_x_imag,
    input  logic signed [31:0] i_ramp_real,
    input  logic signed [31:0] i_ramp_imag,
    input  logic signed [31:0] i_deriv_real,
    input  logic signed [31:0] i_deriv_imag,
    input  logic [14:0]        i_bin_index,
    output logic               o_result_valid,
    output logic signed [15:0] o_level_db,
    output logic [20:0]        o_freq_hz,
    output logic signed [23:0] o_time_offset,
    output logic               o_reassigned,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [17:0]        i_cfg_data
);

    // The time divider needs MAX_FFT_LOG2 + 8 quotient bits before the
    // clamp at N/2 samples (Q8) takes over.
    localparam int LG_W   = $clog2(MAX_FFT_LOG2 + 1);
    localparam int HALF_W = MAX_FFT_LOG2;
    localparam int TSH    = MAX_FFT_LOG2;
    localparam int TSTEPS = TSH + 8;
    localparam int NSTG   = srb_pkg::STG_OUT;

    // ------------------------------------------------------------------
    // Configuration registers. The user must let writes arrive only while the pipe is
    // empty, so every stage may read them directly; the block does not enforce this.
    // ------------------------------------------------------------------
    logic [3:0]         r_fft_log2;
    logic [17:0]        r_fs;
    logic signed [15:0] r_floor;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fft_log2 <= srb_pkg::FFT_LOG2_RST;
            r_fs       <= srb_pkg::FS_RST;
            r_floor    <= srb_pkg::FLOOR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (srb_pkg::t_cfg_idx'(i_cfg_index))
                srb_pkg::CFG_FFT_SIZE_LOG2:   r_fft_log2 <= i_cfg_data[3:0];
                srb_pkg::CFG_SAMPLE_RATE_HZ:  r_fs       <= i_cfg_data;
                srb_pkg::CFG_ENERGY_FLOOR_DB: r_floor    <= $signed(i_cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    // Transform size clamped to the supported range, and N/2.
    logic [LG_W-1:0]   lg;
    logic [HALF_W-1:0] half;

    always_comb begin
        if (r_fft_log2 < 4'd2) begin
            lg = LG_W'(2);
        end else if (int'(r_fft_log2) > MAX_FFT_LOG2) begin
            lg = LG_W'(MAX_FFT_LOG2);
        end else begin
            lg = LG_W'(r_fft_log2);
        end
        half = HALF_W'(1) << (lg - LG_W'(1));
    end

    // ------------------------------------------------------------------
    // Valid bits travel with the data; nothing ever stalls.
    // ------------------------------------------------------------------
    logic            w_accept;
    logic [NSTG:1]   r_vld;

    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-1:1], w_accept};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the six products, k * fs and the two checks on the bin index.
    // ------------------------------------------------------------------
    logic signed [63:0] r_pxx, r_pyy, r_ta, r_tb, r_fa, r_fb;
    logic [32:0]        r_kfs;
    logic               r_knz, r_klt;

    always_ff @(posedge i_clk) begin
        r_pxx <= i_x_real * i_x_real;
        r_pyy <= i_x_imag * i_x_imag;
        r_ta  <= i_ramp_real * i_x_real;
        r_tb  <= i_ramp_imag * i_x_imag;
        r_fa  <= i_deriv_imag * i_x_real;
        r_fb  <= i_deriv_real * i_x_imag;
        r_kfs <= 33'(i_bin_index) * 33'(r_fs);
        r_knz <= i_bin_index != 15'd0;
        r_klt <= 32'(i_bin_index) < 32'(half);
    end

    // ------------------------------------------------------------------
    // Stage 2: power, the two numerators as sign and magnitude, and the
    // bin-centre frequency in Q4 Hz.
    // ------------------------------------------------------------------
    srb_pkg::t_side     r_side [srb_pkg::STG_SUM:NSTG-1];
    logic [63:0]        r_p2, r_tn2, r_fn2;
    logic signed [64:0] tsum, fsum;
    logic [37:0]        cnum, cshift;
    srb_pkg::t_side     side2;

    always_comb begin
        tsum  = 65'(r_ta) + 65'(r_tb);
        fsum  = 65'(r_fa) - 65'(r_fb);
        cnum  = 38'({r_kfs, 4'b0000}) + 38'(half);
        cshift = cnum >> lg;
        side2 = '0;
        side2.centre = (|cshift[37:21]) ? srb_pkg::FREQ_MAX : cshift[20:0];
        side2.tneg   = tsum[64];
        side2.fneg   = fsum[64];
        side2.k_ok   = r_knz && r_klt;
        side2.p_nz   = (r_pxx != 64'sd0) || (r_pyy != 64'sd0);
    end

    always_ff @(posedge i_clk) begin
        r_side[srb_pkg::STG_SUM] <= side2;
        r_p2  <= 64'(r_pxx) + 64'(r_pyy);
        r_tn2 <= tsum[64] ? 64'(-tsum) : tsum[63:0];
        r_fn2 <= fsum[64] ? 64'(-fsum) : fsum[63:0];
    end

    // ------------------------------------------------------------------
    // Stage 3: divider set-up and leading-one search per 16-bit chunk.
    // A quotient that would pass its bound is flagged here, so the
    // dividers only produce the bits below it.
    // ------------------------------------------------------------------
    srb_pkg::t_div    r_div [srb_pkg::STG_PREP:srb_pkg::STG_DIV_END];
    srb_pkg::t_div    div_init;
    logic [3:0]       cnz;
    logic [3:0]       cpos [4];
    logic [3:0]       r_cnz;
    logic [3:0]       r_cpos [4];

    always_comb begin
        div_init       = '0;
        div_init.p     = r_p2;
        div_init.tovf  = (64 + TSH)'(r_tn2) >= {r_p2, TSH'(0)};
        div_init.fovf  = {2'b00, r_fn2} >= {r_p2, 2'b00};
        div_init.trem  = r_tn2 >> TSH;
        div_init.tfeed = r_tn2 << (64 - TSH);
        div_init.frem  = r_fn2 >> 2;
        div_init.ffeed = r_fn2 << 62;
        for (int c = 0; c < 4; c++) begin
            cnz[c]  = |r_p2[16*c +: 16];
            cpos[c] = 4'd0;
            for (int b = 0; b < 16; b++) begin
                if (r_p2[16*c + b]) begin
                    cpos[c] = 4'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_div[srb_pkg::STG_PREP] <= div_init;
        r_cnz  <= cnz;
        r_cpos <= cpos;
    end

    // ------------------------------------------------------------------
    // Long dividers share p: a ratio bit per stage, a time bit in the first TSTEPS.
    // ------------------------------------------------------------------
    for (genvar j = 0; j < srb_pkg::FSTEPS; j++) begin : g_div
        localparam int S = srb_pkg::STG_PREP + 1 + j;
        srb_pkg::t_div nd;
        logic [64:0]   fsh, tsh;
        logic          fge, tge;

        always_comb begin
            nd  = r_div[S-1];
            fsh = {r_div[S-1].frem, r_div[S-1].ffeed[63]};
            fge = fsh >= {1'b0, r_div[S-1].p};
            nd.frem  = fge ? 64'(fsh - {1'b0, r_div[S-1].p}) : fsh[63:0];
            nd.ffeed = r_div[S-1].ffeed << 1;
            nd.fq    = {r_div[S-1].fq[32:0], fge};
            tsh = {r_div[S-1].trem, r_div[S-1].tfeed[63]};
            tge = tsh >= {1'b0, r_div[S-1].p};
            if (j < TSTEPS) begin
                nd.trem  = tge ? 64'(tsh - {1'b0, r_div[S-1].p}) : tsh[63:0];
                nd.tfeed = r_div[S-1].tfeed << 1;
                nd.tq    = {r_div[S-1].tq[22:0], tge};
            end
        end

        always_ff @(posedge i_clk) begin
            r_div[S] <= nd;
        end
    end

    // ------------------------------------------------------------------
    // Level path: exponent, Q30 mantissa, then sixteen squarings that each
    // give one fraction bit of log2(P).
    // ------------------------------------------------------------------
    localparam int LM_LO = srb_pkg::STG_NORM;
    localparam int LM_HI = srb_pkg::STG_NORM + srb_pkg::SQ_STEPS;

    logic [5:0]  r_e;
    logic [5:0]  e_sel;
    logic [30:0] nm;
    logic [30:0] r_lm [LM_LO:LM_HI];
    logic [15:0] r_lf [LM_LO:LM_HI];
    logic [5:0]  r_le [LM_LO:LM_HI];

    always_comb begin
        e_sel = 6'd0;
        for (int c = 0; c < 4; c++) begin
            if (r_cnz[c]) begin
                e_sel = {2'(c), r_cpos[c]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= e_sel;
    end

    always_comb begin
        if (r_e >= 6'd30) begin
            nm = 31'(r_div[srb_pkg::STG_EXP].p >> (r_e - 6'd30));
        end else begin
            nm = 31'(r_div[srb_pkg::STG_EXP].p << (6'd30 - r_e));
        end
    end

    always_ff @(posedge i_clk) begin
        r_lm[LM_LO] <= nm;
        r_lf[LM_LO] <= '0;
        r_le[LM_LO] <= r_e;
    end

    for (genvar i = LM_LO + 1; i <= LM_HI; i++) begin : g_sq
        logic [61:0] sq;

        always_comb begin
            sq = 62'(r_lm[i-1]) * 62'(r_lm[i-1]);
        end

        always_ff @(posedge i_clk) begin
            r_lm[i] <= sq[61] ? sq[61:31] : sq[60:30];
            r_lf[i] <= {r_lf[i-1][14:0], sq[61]};
            r_le[i] <= r_le[i-1];
        end
    end

    // Net log2 relative to full scale, then the scaling to dB in Q8.
    logic signed [23:0] r_lnet;
    logic signed [42:0] r_prod;
    logic [6:0]         lbase;

    assign lbase = 7'(2 * (int'(lg) + 15));

    always_ff @(posedge i_clk) begin
        r_lnet <= $signed({2'b00, r_le[LM_HI], r_lf[LM_HI]}) - $signed({1'b0, lbase, 16'h0000});
        r_prod <= 43'(r_lnet) * $signed(43'(srb_pkg::LOG_DB_Q16)) + 43'sd8388608;
    end

    // ------------------------------------------------------------------
    // Side-band stages: pass through, with the level, qualification and
    // time offset and ratio flag filled in where they become known.
    // ------------------------------------------------------------------
    srb_pkg::t_side     side_db, side_q, side_t;
    logic signed [18:0] dbw;
    logic [23:0]        lim, tm;
    logic [47:0]        r_cprod;

    always_comb begin
        side_db = r_side[srb_pkg::STG_DB-1];
        dbw     = r_prod[42:24];
        if (!side_db.p_nz) begin
            side_db.db = srb_pkg::DB_MIN;
        end else if (dbw < 19'(srb_pkg::DB_MIN)) begin
            side_db.db = srb_pkg::DB_MIN;
        end else if (dbw > 19'(srb_pkg::DB_MAX)) begin
            side_db.db = srb_pkg::DB_MAX;
        end else begin
            side_db.db = dbw[15:0];
        end

        side_q      = r_side[srb_pkg::STG_QUAL-1];
        side_q.qual = side_q.k_ok && side_q.p_nz && (side_q.db >= r_floor);

        // Time offset: clamped at N/2 samples, sign opposite to Re{X_T X*}.
        side_t = r_side[srb_pkg::STG_CMUL-1];
        lim    = 24'(half) << 8;
        if (r_div[srb_pkg::STG_DIV_END].tovf || r_div[srb_pkg::STG_DIV_END].tq >= lim) begin
            tm = lim;
        end else begin
            tm = r_div[srb_pkg::STG_DIV_END].tq;
        end
        side_t.toff = side_t.tneg ? $signed(tm) : -$signed(tm);
        side_t.rok  = !r_div[srb_pkg::STG_DIV_END].fovf;
    end

    for (genvar s = srb_pkg::STG_SUM + 1; s < NSTG; s++) begin : g_side
        if (s == srb_pkg::STG_DB) begin : g_db
            always_ff @(posedge i_clk) begin
                r_side[s] <= side_db;
            end
        end else if (s == srb_pkg::STG_QUAL) begin : g_qual
            always_ff @(posedge i_clk) begin
                r_side[s] <= side_q;
            end
        end else if (s == srb_pkg::STG_CMUL) begin : g_toff
            always_ff @(posedge i_clk) begin
                r_side[s] <= side_t;
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Frequency correction: ratio to cycles per sample, then to Q4 Hz.
    // ------------------------------------------------------------------
    logic [24:0] r_c;
    logic [42:0] r_cfs;
    logic [23:0] r_corr;
    logic [48:0] csum;
    logic [47:0] corr_sum;

    assign csum     = 49'(r_cprod) + 49'd8388608;
    assign corr_sum = {1'b0, r_cfs, 4'b0000} + 48'd8388608;

    always_ff @(posedge i_clk) begin
        r_cprod <= 48'(r_div[srb_pkg::STG_DIV_END].fq[33:8]) * 48'(srb_pkg::INV_2PI_Q24);
        r_c     <= csum[48:24];
        r_cfs   <= 43'(r_c) * 43'(r_fs);
        r_corr  <= corr_sum[47:24];
    end

    // ------------------------------------------------------------------
    // Output stage: choose the reassigned or the centre frequency.
    // ------------------------------------------------------------------
    srb_pkg::t_side fin;
    logic [39:0]    corr_sh, fs40;
    logic [24:0]    fsel;
    logic           ok;
    logic [20:0]    n_freq;
    logic           n_reas;
    logic [20:0]    r_freq;
    logic signed [15:0] r_level;
    logic signed [23:0] r_toff;
    logic           r_reas;

    always_comb begin
        fin     = r_side[NSTG-1];
        corr_sh = 40'(r_corr) << lg;
        fs40    = (40'(r_fs) << 5) + (40'(r_fs) << 3);
        ok      = corr_sh <= fs40;
        fsel    = '0;
        if (fin.fneg) begin
            if (25'(r_corr) > 25'(fin.centre)) begin
                ok = 1'b0;
            end else begin
                fsel = 25'(fin.centre) - 25'(r_corr);
            end
        end else begin
            fsel = 25'(fin.centre) + 25'(r_corr);
        end
        n_freq = fin.centre;
        n_reas = 1'b0;
        if (fin.qual && fin.rok && ok && fsel >= srb_pkg::FREQ_MIN_Q4) begin
            n_freq = (|fsel[24:21]) ? srb_pkg::FREQ_MAX : fsel[20:0];
            n_reas = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[NSTG-1]) begin
            r_level <= fin.db;
            r_freq  <= n_freq;
            r_toff  <= fin.qual ? fin.toff : 24'sd0;
            r_reas  <= n_reas;
        end
    end

    assign o_result_valid = r_vld[NSTG];
    assign o_level_db     = r_level;
    assign o_freq_hz      = r_freq;
    assign o_time_offset  = r_toff;
    assign o_reassigned   = r_reas;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SRB_ASSERT_NEXT(a_enter, i_clk, i_rst_n, w_accept, r_vld[1], "request not entered")
    `SRB_ASSERT_IMPL(a_latency, i_clk, i_rst_n, o_result_valid, $past(w_accept, NSTG), "result without request")
    `SRB_ASSERT_IMPL(a_min_freq, i_clk, i_rst_n, o_result_valid && o_reassigned, o_freq_hz >= 21'd16, "reassigned below 1 Hz")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for spectral_reassignment_bin
// Drives FFT bins through the block under a series of register settings and
// compares every level, frequency, time offset and flag against an in-bench
// predictor of the per-bin reassignment arithmetic.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PER_PHASE = 258;
    localparam int N_PHASES = 7;

    typedef logic [127:0] t_u128;

    typedef struct {
        logic signed [15:0] level_db;
        logic [20:0]        freq_hz;
        logic signed [23:0] time_offset;
        logic               reassigned;
    } t_bin_result;

    // Scoreboard: holds its own copy of the registers and the queue of
    // bin results still owed by the block.
    class bin_scoreboard;
        logic [3:0]         fft_log2;
        logic [17:0]        fs;
        logic signed [15:0] floor_db;
        t_bin_result        owed_q[$];
        int                 mismatches;

        function new();
            fft_log2   = srb_pkg::FFT_LOG2_RST;
            fs         = srb_pkg::FS_RST;
            floor_db   = srb_pkg::FLOOR_RST;
            mismatches = 0;
        endfunction

        function void set_reg(srb_pkg::t_cfg_idx idx, logic [17:0] data);
            case (idx)
                srb_pkg::CFG_FFT_SIZE_LOG2:   fft_log2 = data[3:0];
                srb_pkg::CFG_SAMPLE_RATE_HZ:  fs = data;
                srb_pkg::CFG_ENERGY_FLOOR_DB: floor_db = data[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Level, centre frequency and, for qualifying bins, the reassigned
        // frequency and time offset of one bin.
        function t_bin_result reassign_bin(longint re, longint im, longint rt, longint it,
                                           longint rd, longint id, int unsigned k);
            t_u128 p, m, centre, half, tn, fn, tm, r, cap, c, corr, f;
            logic signed [127:0] tsum, fsum;
            longint lnet, prod, db, tval;
            int lg, e;
            logic [15:0] frac;
            logic ok;
            t_bin_result res;
            lg = fft_log2;
            if (lg < 2) lg = 2;
            if (lg > 15) lg = 15;
            half = t_u128'(1) << (lg - 1);
            p = re * re + im * im;

            // log2 of the power in Q16, then scaled to dB in Q8.
            if (p == 0) begin
                db = srb_pkg::DB_MIN;
            end else begin
                e = 63;
                while (p[e] == 1'b0) e--;
                m = (e >= 30) ? (p >> (e - 30)) : (p << (30 - e));
                frac = '0;
                for (int i = 0; i < 16; i++) begin
                    m = (m * m) >> 30;
                    frac = frac << 1;
                    if (m >= (t_u128'(1) << 31)) begin
                        m = m >> 1;
                        frac[0] = 1'b1;
                    end
                end
                lnet = longint'(e) * 65536 + longint'(frac) - 2 * (longint'(lg) + 15) * 65536;
                prod = lnet * longint'(srb_pkg::LOG_DB_Q16) + (longint'(1) << 23);
                db = prod >>> 24;
                if (db < srb_pkg::DB_MIN) db = srb_pkg::DB_MIN;
                if (db > srb_pkg::DB_MAX) db = srb_pkg::DB_MAX;
            end

            centre = (t_u128'(k) * fs * 16 + half) >> lg;
            if (centre > srb_pkg::FREQ_MAX) centre = srb_pkg::FREQ_MAX;
            res.level_db    = db[15:0];
            res.freq_hz     = centre[20:0];
            res.time_offset = '0;
            res.reassigned  = 1'b0;

            if (k > 0 && k < half && p != 0 && db >= floor_db) begin
                tsum = rt * re + it * im;
                fsum = id * re - rd * im;
                tn = (tsum < 0) ? -tsum : tsum;
                fn = (fsum < 0) ? -fsum : fsum;
                tm = (tn << 8) / p;
                if (tm > (half << 8)) tm = half << 8;
                tval = (tsum < 0) ? longint'(tm) : -longint'(tm);
                res.time_offset = tval[23:0];
                cap = t_u128'(4) << 32;
                r = (fn << 32) / p;
                if (r < cap) begin
                    c = ((r >> 8) * srb_pkg::INV_2PI_Q24 + (t_u128'(1) << 23)) >> 24;
                    corr = (c * fs * 16 + (t_u128'(1) << 23)) >> 24;
                    ok = (corr << lg) <= t_u128'(fs) * 40;
                    f = '0;
                    if (fsum < 0) begin
                        if (corr > centre) ok = 1'b0;
                        else f = centre - corr;
                    end else begin
                        f = centre + corr;
                    end
                    if (ok && f >= 16) begin
                        res.freq_hz = (f > srb_pkg::FREQ_MAX) ? srb_pkg::FREQ_MAX : f[20:0];
                        res.reassigned = 1'b1;
                    end
                end
            end
            return res;
        endfunction

        function void note_request(longint re, longint im, longint rt, longint it,
                                   longint rd, longint id, int unsigned k);
            owed_q.push_back(reassign_bin(re, im, rt, it, rd, id, k));
        endfunction

        function void check_result(t_bin_result got);
            t_bin_result want;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result with no request outstanding");
                return;
            end
            want = owed_q.pop_front();
            if (got.level_db !== want.level_db || got.freq_hz !== want.freq_hz ||
                got.time_offset !== want.time_offset || got.reassigned !== want.reassigned) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: level %0d/%0d freq %0d/%0d offset %0d/%0d flag %0d/%0d",
                             want.level_db, got.level_db, want.freq_hz, got.freq_hz,
                             want.time_offset, got.time_offset,
                             want.reassigned, got.reassigned);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_x_real = '0;
    logic signed [31:0] i_x_imag = '0;
    logic signed [31:0] i_ramp_real = '0;
    logic signed [31:0] i_ramp_imag = '0;
    logic signed [31:0] i_deriv_real = '0;
    logic signed [31:0] i_deriv_imag = '0;
    logic [14:0]        i_bin_index = '0;
    logic               o_result_valid;
    logic signed [15:0] o_level_db;
    logic [20:0]        o_freq_hz;
    logic signed [23:0] o_time_offset;
    logic               o_reassigned;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [17:0]        i_cfg_data = '0;

    bin_scoreboard sb = new();
    int  idle_cycles = 0;
    int  n_sent = 0;
    int  cur_half = 1024;

    spectral_reassignment_bin u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_x_real       (i_x_real),
        .i_x_imag       (i_x_imag),
        .i_ramp_real    (i_ramp_real),
        .i_ramp_imag    (i_ramp_imag),
        .i_deriv_real   (i_deriv_real),
        .i_deriv_imag   (i_deriv_imag),
        .i_bin_index    (i_bin_index),
        .o_result_valid (o_result_valid),
        .o_level_db     (o_level_db),
        .o_freq_hz      (o_freq_hz),
        .o_time_offset  (o_time_offset),
        .o_reassigned   (o_reassigned),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Monitor: everything is sampled at the rising edge, before the block's
    // own updates of that edge land, so requests, results and register
    // writes are seen exactly as the block takes them.
    always @(posedge i_clk) begin
        t_bin_result got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_reg(srb_pkg::t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (start && !busy)
                sb.note_request(i_x_real, i_x_imag, i_ramp_real, i_ramp_imag,
                                i_deriv_real, i_deriv_imag, i_bin_index);
            if (o_result_valid) begin
                got.level_db    = o_level_db;
                got.freq_hz     = o_freq_hz;
                got.time_offset = o_time_offset;
                got.reassigned  = o_reassigned;
                sb.check_result(got);
            end
        end
    end

    // Watchdog: counts cycles in which no request, result or register write
    // is taken. Reaching the limit means the block has hung.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Presents one request and holds it until the block takes it. The task
    // returns in the time step of the accepting edge, so the caller may
    // either present the next request or lower start in that same step.
    task automatic send_bin(logic signed [31:0] xr, logic signed [31:0] xi,
                            logic signed [31:0] rr, logic signed [31:0] ri,
                            logic signed [31:0] dr, logic signed [31:0] di,
                            logic [14:0] k);
        i_x_real     <= xr;
        i_x_imag     <= xi;
        i_ramp_real  <= rr;
        i_ramp_imag  <= ri;
        i_deriv_real <= dr;
        i_deriv_imag <= di;
        i_bin_index  <= k;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        n_sent++;
    endtask

    // Occasional random gaps between requests; none within the long stretch in
    // the middle of the run, other than the drains between phases.
    task automatic sender_gap();
        if (!(n_sent >= 700 && n_sent < 1100) && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every owed result has come back. Each
    // request yields exactly one result, so nothing is left in flight then.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(srb_pkg::t_cfg_idx idx, logic [17:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One random bin. Most bins are shaped like real spectra: the derivative
    // spectrum is close to j*a*X, so the frequency correction stays within a
    // few bins, and the ramp spectrum is a scaled copy of X. The rest are
    // raw random words, which mostly exercise the fallbacks.
    task automatic send_random_bin();
        logic signed [31:0] xr, xi, rr, ri, dr, di;
        logic [14:0] k;
        int sh, dsh, rsh;
        if ($urandom_range(0, 9) < 2) begin
            xr = $urandom; xi = $urandom; rr = $urandom;
            ri = $urandom; dr = $urandom; di = $urandom;
        end else begin
            sh  = $urandom_range(0, 24);
            dsh = $urandom_range(4, 26);
            rsh = $urandom_range(0, 20);
            xr = $signed($urandom) >>> sh;
            xi = $signed($urandom) >>> (sh + $urandom_range(0, 3));
            dr = -(xi >>> dsh);
            di = xr >>> dsh;
            if ($urandom_range(0, 1)) begin
                dr = -dr;
                di = -di;
            end
            dr = dr ^ 32'($urandom_range(0, 3));
            rr = (xr >>> rsh) ^ 32'($urandom_range(0, 15));
            ri = (xi >>> rsh) ^ 32'($urandom_range(0, 15));
            if ($urandom_range(0, 1)) begin
                rr = -rr;
                ri = -ri;
            end
        end
        if ($urandom_range(0, 9) < 8)
            k = $urandom_range(1, cur_half - 1);
        else
            k = $urandom_range(0, 32767);
        send_bin(xr, xi, rr, ri, dr, di, k);
    endtask

    // Directed bins under the reset settings (N = 2048, half = 1024).
    task automatic send_directed();
        send_bin(0, 0, S_MAX, S_MIN, S_MAX, S_MIN, 5);            // zero power
        send_bin(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 0);    // largest power, DC bin
        send_bin(S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, 1023); // full scale, top interior
        send_bin(S_MIN, S_MAX, 0, 0, 0, 0, 1);
        send_bin(1, 0, 1, 0, 0, 1, 7);                            // far below the floor
        send_bin(32'sd1000000, 32'sd20000, 0, 0, 0, 0, 1024);     // Nyquist bin
        send_bin(32'sd1000000, 32'sd20000, 0, 0, 0, 0, 2000);     // beyond N/2
        send_bin(32'sd1000000, 32'sd20000, 0, 0, 0, 0, 32767);    // centre saturates
        // Small upward and downward corrections.
        send_bin(32'sd3000000, -32'sd1000000, 32'sd5000, 32'sd7000,
                 32'sd1000, 32'sd3000, 100);
        send_bin(32'sd3000000, -32'sd1000000, -32'sd5000, 32'sd7000,
                 -32'sd1000, -32'sd3000, 100);
        // Ratio of four or more: the correction is dropped.
        send_bin(32'sd1000000, 0, 0, 0, 0, 32'sd5000000, 300);
        // Correction of more than two and a half bins.
        send_bin(32'sd1000000, 0, 0, 0, 0, 32'sd10000, 300);
        // Downward correction short of the centre of bin one, and to below 1 Hz.
        send_bin(32'sd1000000, 0, 0, 0, 0, -32'sd2500, 1);
        send_bin(32'sd1000000, 0, 0, 0, 0, -32'sd2950, 1);
        // Time offset clamped in both directions, then an exact zero.
        send_bin(32'sd100000, 0, S_MAX, 0, 0, 0, 50);
        send_bin(32'sd100000, 0, S_MIN, 0, 0, 0, 50);
        send_bin(32'sd100000, 32'sd100000, 32'sd100000, -32'sd100000, 0, 0, 50);
        // Levels of about -74 dB, above the reset floor of -80 dB.
        send_bin(32'sd13000, 0, 32'sd100, 0, 0, 32'sd10, 200);
        send_bin(32'sd14000, 0, 32'sd100, 0, 0, 32'sd10, 200);
    endtask

    initial begin
        int lg_set [N_PHASES] = '{11, 2, 15, 0, 1, 10, 13};
        int fs_set [N_PHASES] = '{48000, 8000, 192000, 262143, 0, 44100, 96000};
        int flr_set[N_PHASES] = '{-20480, -30720, 0, -30720, -12000, -30720, -6000};
        int lg_eff;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // Registers change only with the pipeline empty.
            drain();
            write_reg(srb_pkg::CFG_FFT_SIZE_LOG2,
                      18'(lg_set[ph]) | 18'({$urandom_range(0, 3), 4'b0}));
            write_reg(srb_pkg::CFG_SAMPLE_RATE_HZ, 18'(fs_set[ph]));
            write_reg(srb_pkg::CFG_ENERGY_FLOOR_DB,
                      {2'($urandom_range(0, 3)), 16'(flr_set[ph])});
            lg_eff = (lg_set[ph] < 2) ? 2 : lg_set[ph];
            cur_half = 1 << (lg_eff - 1);
            if (ph == 0) send_directed();
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_random_bin();
                // Hold-off: once, the sender waits for every result.
                if (ph == 1 && n == RANDOM_PER_PHASE / 2) drain();
                sender_gap();
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
